### hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Decoded length saturates here (never above 16 bits)
  localparam logic [31:0] MAX_LENGTH = 32'd65535;
  localparam logic [15:0] LEN_CAP    = (MAX_LENGTH > 32'd65535) ? 16'hFFFF
                                                                : MAX_LENGTH[15:0];

  // Default depth of the command queue between front and back end
  localparam int unsigned CMD_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_HEX  = 3'd2,
    ST_BAD_SURR = 3'd3,
    ST_BAD_ESC  = 3'd4,
    ST_NO_QUOTE = 3'd5,
    ST_CTRL     = 3'd6
  } status_e;

  // One command: a code point to expand into nbm1+1 UTF-8 bytes, or a
  // single status result (done / error).
  typedef struct packed {
    status_e      status;
    logic [1:0]   nbm1;
    logic [20:0]  cp;
    logic [15:0]  len;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } head_t;

endpackage

### hdl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Parses the raw byte stream: escapes, hex groups, surrogate pairs, and
// the running byte count. Emits one command per byte that gives results.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_start_i,
  input  logic          q_full_i,
  output jsu_pkg::push_t push_o
);
  import jsu_pkg::*;

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_STR  = 7'b0000010,
    M_ESC  = 7'b0000100,
    M_HEX1 = 7'b0001000,
    M_SBS  = 7'b0010000,
    M_SU   = 7'b0100000,
    M_HEX2 = 7'b1000000
  } mode_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic [15:0] hex_accum_q, hex_accum_d;
  logic [15:0] high_half_q, high_half_d;
  logic [15:0] count_q, count_d;

  logic        accept;
  logic        hv_ok;
  logic [3:0]  hv;
  logic [15:0] acc_new;
  logic        hex_done;
  logic [20:0] pair_cp;
  logic [16:0] count_sum;
  push_t       push;

  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [7:0] t;
    t = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t = c - 8'h57;
      return {1'b1, t[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t = c - 8'h37;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic logic [1:0] bmp_nbm1(logic [15:0] cp);
    if (cp <= 16'h007F) return 2'd0;
    if (cp <= 16'h07FF) return 2'd1;
    return 2'd2;
  endfunction

  assign accept     = in_valid_i && !q_full_i;
  assign in_ready_o = !q_full_i;

  assign {hv_ok, hv} = hex_val(in_byte_i);
  assign acc_new     = {hex_accum_q[11:0], hv};
  assign hex_done    = (hex_count_q == 2'd3);
  // {high[9:0], low[9:0]} + 0x10000
  assign pair_cp     = {1'b0, high_half_q[9:0], acc_new[9:0]} + 21'h10000;

  always_comb begin
    mode_d      = mode_q;
    hex_count_d = hex_count_q;
    hex_accum_d = hex_accum_q;
    high_half_d = high_half_q;
    push        = '0;
    push.cmd.status = ST_DATA;

    if (accept) begin
      if (in_start_i) begin
        mode_d      = (in_byte_i == CH_QUOTE) ? M_STR : M_IDLE;
        hex_count_d = '0;
        hex_accum_d = '0;
        high_half_d = '0;
      end else begin
        case (mode_q)
          M_STR: begin
            if (in_byte_i == CH_QUOTE) begin
              push.valid      = 1'b1;
              push.cmd.status = ST_DONE;
              push.cmd.len    = count_q;
              mode_d          = M_IDLE;
            end else if (in_byte_i == CH_BSLASH) begin
              mode_d = M_ESC;
            end else if (in_byte_i == 8'h00) begin
              push.valid      = 1'b1;
              push.cmd.status = ST_NO_QUOTE;
              mode_d          = M_IDLE;
            end else if (in_byte_i < 8'h20) begin
              push.valid      = 1'b1;
              push.cmd.status = ST_CTRL;
              mode_d          = M_IDLE;
            end else begin
              push.valid  = 1'b1;
              push.cmd.cp = {13'd0, in_byte_i};
            end
          end
          M_ESC: begin
            mode_d     = M_STR;
            push.valid = 1'b1;
            case (in_byte_i)
              CH_QUOTE, CH_BSLASH, CH_SLASH: push.cmd.cp = {13'd0, in_byte_i};
              CH_B: push.cmd.cp = 21'h08;
              CH_F: push.cmd.cp = 21'h0C;
              CH_N: push.cmd.cp = 21'h0A;
              CH_R: push.cmd.cp = 21'h0D;
              CH_T: push.cmd.cp = 21'h09;
              CH_U: begin
                push.valid  = 1'b0;
                mode_d      = M_HEX1;
                hex_count_d = '0;
                hex_accum_d = '0;
              end
              default: begin
                push.cmd.status = ST_BAD_ESC;
                mode_d          = M_IDLE;
              end
            endcase
          end
          M_HEX1, M_HEX2: begin
            if (!hv_ok) begin
              push.valid      = 1'b1;
              push.cmd.status = ST_BAD_HEX;
              mode_d          = M_IDLE;
            end else begin
              hex_accum_d = acc_new;
              hex_count_d = hex_count_q + 2'd1;
              if (hex_done) begin
                if (mode_q == M_HEX1) begin
                  if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                    high_half_d = acc_new;
                    mode_d      = M_SBS;
                  end else begin
                    push.valid    = 1'b1;
                    push.cmd.cp   = {5'd0, acc_new};
                    push.cmd.nbm1 = bmp_nbm1(acc_new);
                    mode_d        = M_STR;
                  end
                end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                  push.valid      = 1'b1;
                  push.cmd.status = ST_BAD_SURR;
                  mode_d          = M_IDLE;
                end else begin
                  push.valid    = 1'b1;
                  push.cmd.cp   = pair_cp;
                  push.cmd.nbm1 = 2'd3;
                  mode_d        = M_STR;
                end
              end
            end
          end
          M_SBS: begin
            if (in_byte_i == CH_BSLASH) begin
              mode_d = M_SU;
            end else begin
              push.valid      = 1'b1;
              push.cmd.status = ST_BAD_SURR;
              mode_d          = M_IDLE;
            end
          end
          M_SU: begin
            if (in_byte_i == CH_U) begin
              mode_d      = M_HEX2;
              hex_count_d = '0;
              hex_accum_d = '0;
            end else begin
              push.valid      = 1'b1;
              push.cmd.status = ST_BAD_SURR;
              mode_d          = M_IDLE;
            end
          end
          M_IDLE: ;
          default: mode_d = M_IDLE;
        endcase
      end
    end
  end

  // Count grows by the UTF-8 length of each data command, saturating
  assign count_sum = {1'b0, count_q} + {15'd0, push.cmd.nbm1} + 17'd1;

  always_comb begin
    count_d = count_q;
    if (accept && in_start_i) begin
      count_d = '0;
    end else if (push.valid && push.cmd.status == ST_DATA) begin
      count_d = (count_sum > {1'b0, LEN_CAP}) ? LEN_CAP : count_sum[15:0];
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_IDLE;
      hex_count_q <= '0;
      hex_accum_q <= '0;
      high_half_q <= '0;
      count_q     <= '0;
    end else begin
      mode_q      <= mode_d;
      hex_count_q <= hex_count_d;
      hex_accum_q <= hex_accum_d;
      high_half_q <= high_half_d;
      count_q     <= count_d;
    end
  end

  a_push_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> (in_valid_i && !q_full_i))
    else $error("command pushed without an accepted byte");

  a_end_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.valid && push_o.cmd.status != ST_DATA) |=> (mode_q == M_IDLE))
    else $error("string end or error did not return to idle");

  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= LEN_CAP)
    else $error("byte count above cap");

endmodule

### hdl/jsu_cmd_fifo.sv
// ----------------------------------------------------------------------------
// jsu_cmd_fifo
// Small command queue between the parser and the UTF-8 byte serializer.
// ----------------------------------------------------------------------------
module jsu_cmd_fifo #(
  parameter int unsigned Depth = jsu_pkg::CMD_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jsu_pkg::push_t push_i,
  output logic           full_o,
  input  logic           pop_i,
  output jsu_pkg::head_t head_o
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.cmd   = mem_q[rptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !head_o.empty;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_i.cmd;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o))
    else $error("push into full command queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && head_o.empty))
    else $error("pop from empty command queue");

  a_count_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)))
    else $error("queue count did not follow push");

endmodule

### hdl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Expands queued commands into result items, one UTF-8 byte per cycle while
// the output is not held by out_ready_i, into a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  jsu_pkg::head_t  head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic [7:0]      out_byte_o,
  output logic [15:0]     string_length_o,
  output logic            last_o
);
  import jsu_pkg::*;

  logic        valid_q, valid_d;
  logic [1:0]  idx_q, idx_d;
  logic [2:0]  status_q;
  logic [7:0]  byte_q;
  logic [15:0] len_q;
  logic        last_q;
  logic        load;
  logic        final_byte;
  logic [7:0]  data_byte;

  // idx counts from the lead byte; nbm1 = sequence length - 1
  function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [1:0] nbm1,
                                           logic [1:0] idx);
    logic [1:0] r;
    logic [5:0] six;
    logic [7:0] b;
    r = nbm1 - idx;
    case (r)
      2'd0:    six = cp[5:0];
      2'd1:    six = cp[11:6];
      2'd2:    six = cp[17:12];
      default: six = {3'b000, cp[20:18]};
    endcase
    if (nbm1 == 2'd0) begin
      b = cp[7:0];
    end else if (idx != 2'd0) begin
      b = {2'b10, six};
    end else begin
      case (nbm1)
        2'd1:    b = {3'b110, six[4:0]};
        2'd2:    b = {4'b1110, six[3:0]};
        default: b = {5'b11110, six[2:0]};
      endcase
    end
    return b;
  endfunction

  assign load       = !head_i.empty && (!valid_q || out_ready_i);
  assign final_byte = (idx_q == head_i.cmd.nbm1);
  assign pop_o      = load && final_byte;
  assign data_byte  = utf8_byte(head_i.cmd.cp, head_i.cmd.nbm1, idx_q);

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      idx_d   = final_byte ? 2'd0 : idx_q + 2'd1;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= head_i.cmd.status;
      byte_q   <= (head_i.cmd.status == ST_DATA) ? data_byte : 8'd0;
      len_q    <= head_i.cmd.len;
      last_q   <= final_byte;
    end
  end

  assign out_valid_o     = valid_q;
  assign status_o        = status_q;
  assign out_byte_o      = byte_q;
  assign string_length_o = len_q;
  assign last_o          = last_q;

  a_idx_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (idx_q != 2'd0) |-> (!head_i.empty && idx_q <= head_i.cmd.nbm1))
    else $error("byte index without a matching command");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && status_q != ST_DATA) |-> (last_q && byte_q == 8'd0))
    else $error("status result not single and clean");

  a_multi_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && idx_q != 2'd0) |=> (byte_q[7:6] == 2'b10))
    else $error("continuation byte malformed");

endmodule

### hdl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string literal unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle (tuser marks the opening quote of a new
// string) and returns decoded bytes, a done result with the byte length, or
// an error result. The parser accepts a byte every cycle while its command
// queue (CmdDepth entries) has room; the serializer behind it drives one
// result per cycle unless m_axis_tready stalls it, so a \u escape (or pair)
// that becomes two to four UTF-8 bytes takes one result per byte and the
// queue absorbs the burst. A byte passes the queue and the output register
// before its first result. s_axis_tready drops only when the queue is full.
module json_string_unescape_utf8_top #(
  parameter int unsigned CmdDepth = jsu_pkg::CMD_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tuser,   // [0] string_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [2:0] status, [10:3] out_byte,
                                      // [26:11] string_length, rest zero
  output logic        m_axis_tlast
);
  import jsu_pkg::*;

  push_t       push;
  head_t       head;
  logic        q_full;
  logic        pop;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [15:0] str_len;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_start_i (s_axis_tuser),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  jsu_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  jsu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .status_o        (status),
    .out_byte_o      (out_byte),
    .string_length_o (str_len),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, str_len, out_byte, status};

endmodule
